// File: sv/tsra_pkg.sv
package tsra_pkg;

  // one segment descriptor as held in the table memory
  typedef struct packed {
    logic [63:0] seq;
    logic [15:0] len;
    logic [15:0] rp;
    logic        st;
    logic        en;
  } entry_t;

  typedef enum logic [3:0] {
    ST_INSERTED = 4'd0,
    ST_MERGED   = 4'd1,
    ST_DROP     = 4'd2,
    ST_BEFORE   = 4'd3,
    ST_EMPTY    = 4'd4,
    ST_FULL     = 4'd5,
    ST_DATA     = 4'd6,
    ST_NONE     = 4'd7,
    ST_GAP      = 4'd8
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXT,
    S_WALK,
    S_DECIDE,
    S_SHIFT_UP,
    S_INSERT,
    S_CON_RD,
    S_CON_CHK,
    S_SHIFT_DN
  } fsm_t;

  localparam logic        OP_STORE   = 1'b0;
  localparam logic        OP_CONSUME = 1'b1;
  localparam logic [31:0] SEQ_MAX    = 32'hFFFF_FFFF;
  localparam logic [31:0] WRAP_RESET = 32'd14600;

endpackage

// File: sv/tcp_segment_reassembly_table_top.sv
// TCP segment reassembly table for one direction. Descriptors (64-bit
// extended sequence, length, read position, start/end flags) live in one
// synchronous memory of MAX_SEGMENTS entries kept in sequence order. Pulse
// start while busy is low; exactly one result follows, shown for a single
// cycle with done high, and the receiver cannot stall it. A consume reads
// the front entry and, when the front is popped, checks the next entry and
// moves the entries down one at a time. A store on an empty table goes
// straight to the decision. Otherwise a store extends the sequence from
// the front entry, walks the table one entry at a time, decides when it is
// not merged or dropped, and, when a slot is opened, shifts entries up one
// at a time and then writes the new entry; the single read port of the
// table memory sets this pace. The wrap window register may be written
// whenever the block is idle.
module tcp_segment_reassembly_table_top #(
  parameter int MAX_SEGMENTS = 16,
  parameter int MAX_FUTURE   = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [31:0] seq_number,
  input  logic [15:0] payload_len,
  input  logic        syn_flag,
  input  logic        fin_or_rst,
  input  logic [15:0] request_len,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [3:0]  status,
  output logic [31:0] seq_out,
  output logic [15:0] byte_count,
  output logic [15:0] trim_front,
  output logic        start_of_stream,
  output logic        end_of_stream,
  output logic [4:0]  queue_count
);
  import tsra_pkg::*;

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  // table memory
  entry_t mem [MAX_SEGMENTS];
  entry_t rdata;
  logic          we, rd_en;
  logic [IW-1:0] wa, ra;
  entry_t        wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata <= mem[ra];
    end
  end

  // control and working registers
  fsm_t          state, state_next;
  logic [CW-1:0] used, used_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] k, k_next;
  logic [31:0]   ww;
  logic [63:0]   seq_r, seq_r_next;
  logic [15:0]   len_r, len_r_next;
  logic [15:0]   plen_r, plen_r_next;
  logic [15:0]   trim_r, trim_r_next;
  logic [15:0]   req_r, req_r_next;
  logic          syn_r, syn_r_next, fin_r, fin_r_next;
  entry_t        prev, prev_next;
  entry_t        fr, fr_next;
  logic [15:0]   chk, chk_next;

  logic          emit;
  status_t       e_status;
  logic [31:0]   e_seq;
  logic [15:0]   e_cnt, e_trim;
  logic          e_s, e_e;

  // shared terms
  logic [31:0] seq_in;
  logic [31:0] front_lo, seq_lo;
  logic        wrap_dec, wrap_inc;
  logic        w_eq, w_lt, w_ovl, w_drop, w_more;
  logic [63:0] diff_lt, diff_gt;
  logic [15:0] extra;
  logic [CW-1:0] pos_inc;
  logic        d_empty, d_before, d_full, d_pred;
  logic [63:0] prev_end;
  logic        c_read_all, c_req0, c_pop_try, c_match;
  logic [15:0] c_rem, c_chunk;
  logic        su_more, sd_more;
  entry_t      new_ent;

  assign seq_in   = seq_number + {31'd0, syn_flag};
  assign front_lo = rdata.seq[31:0];
  assign seq_lo   = seq_r[31:0];
  assign wrap_dec = (seq_lo > SEQ_MAX - ww) && (front_lo < ww);
  assign wrap_inc = (front_lo > SEQ_MAX - ww) && (seq_lo < ww);

  assign w_eq    = seq_r == rdata.seq;
  assign w_lt    = seq_r < rdata.seq;
  assign diff_lt = rdata.seq - seq_r;
  assign diff_gt = seq_r - rdata.seq;
  assign w_ovl   = {48'd0, rdata.len} > diff_gt;
  assign extra   = rdata.len - diff_gt[15:0];
  assign w_drop  = w_ovl && (len_r <= extra);
  assign pos_inc = pos + CW'(1);
  assign w_more  = pos_inc < used;

  assign prev_end = prev.seq + {48'd0, prev.len};
  assign d_empty  = (len_r == 16'd0) && !syn_r && !fin_r;
  assign d_before = (used != '0) && (pos == '0);
  assign d_full   = {{(32-CW){1'b0}}, used} >= 32'(MAX_SEGMENTS);
  assign d_pred   = (pos != '0) && (prev.rp >= prev.len) && (prev_end == seq_r);

  assign su_more = (k - CW'(1)) > pos;
  assign sd_more = ({1'b0, k} + (CW+1)'(2)) < {1'b0, used};

  assign c_read_all = rdata.rp >= rdata.len;
  assign c_req0     = req_r == 16'd0;
  assign c_rem      = rdata.len - rdata.rp;
  assign c_chunk    = (req_r < c_rem) ? req_r : c_rem;
  assign c_pop_try  = !rdata.en && (req_r >= c_rem) && (used >= CW'(2));
  assign c_match    = rdata.seq == fr.seq + {48'd0, fr.len};

  assign new_ent = '{seq: seq_r, len: len_r, rp: 16'd0, st: syn_r, en: fin_r};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (operation == OP_CONSUME) begin
            state_next = (used == '0) ? S_IDLE : S_CON_RD;
          end else begin
            state_next = (used == '0) ? S_DECIDE : S_EXT;
          end
        end
      end
      S_EXT: state_next = S_WALK;
      S_WALK: begin
        if (w_eq || (!w_lt && w_drop)) begin
          state_next = S_IDLE;
        end else if (w_lt || !w_more) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!d_empty && !d_before && !d_full && !d_pred && used > pos) begin
          state_next = S_SHIFT_UP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SHIFT_UP: state_next = su_more ? S_SHIFT_UP : S_INSERT;
      S_INSERT:   state_next = S_IDLE;
      S_CON_RD: begin
        if (!c_read_all && !c_req0 && c_pop_try) begin
          state_next = S_CON_CHK;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CON_CHK:  state_next = c_match ? S_SHIFT_DN : S_IDLE;
      S_SHIFT_DN: state_next = sd_more ? S_SHIFT_DN : S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath, memory control and result
  always_comb begin
    used_next   = used;
    pos_next    = pos;
    k_next      = k;
    seq_r_next  = seq_r;
    len_r_next  = len_r;
    plen_r_next = plen_r;
    trim_r_next = trim_r;
    req_r_next  = req_r;
    syn_r_next  = syn_r;
    fin_r_next  = fin_r;
    prev_next   = prev;
    fr_next     = fr;
    chk_next    = chk;
    we          = 1'b0;
    wa          = '0;
    wd          = new_ent;
    rd_en       = 1'b0;
    ra          = '0;
    emit        = 1'b0;
    e_status    = ST_NONE;
    e_seq       = '0;
    e_cnt       = '0;
    e_trim      = '0;
    e_s         = 1'b0;
    e_e         = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          seq_r_next  = {32'd0, seq_in};
          len_r_next  = payload_len;
          plen_r_next = payload_len;
          trim_r_next = '0;
          syn_r_next  = syn_flag;
          fin_r_next  = fin_or_rst;
          req_r_next  = request_len;
          pos_next    = '0;
          if (used != '0) begin
            rd_en = 1'b1;
            ra    = '0;
          end else if (operation == OP_CONSUME) begin
            emit = 1'b1;
          end
        end
      end
      // extend the sequence from the front entry
      S_EXT: begin
        if (wrap_dec) begin
          seq_r_next = {rdata.seq[63:32] - 32'd1, seq_lo};
        end else if (wrap_inc) begin
          seq_r_next = {rdata.seq[63:32] + 32'd1, seq_lo};
        end else begin
          seq_r_next = {rdata.seq[63:32], seq_lo};
        end
        rd_en = 1'b1;
        ra    = '0;
      end
      // compare against one descriptor per cycle
      S_WALK: begin
        if (w_eq) begin
          wd = rdata;
          if (len_r > rdata.len) begin
            wd.len = len_r;
          end
          we       = 1'b1;
          wa       = pos[IW-1:0];
          emit     = 1'b1;
          e_status = ST_MERGED;
          e_seq    = rdata.seq[31:0];
          e_cnt    = wd.len;
          e_trim   = trim_r;
          e_s      = rdata.st;
          e_e      = rdata.en;
        end else if (w_lt) begin
          if ({48'd0, len_r} > diff_lt) begin
            len_r_next = diff_lt[15:0];
          end
        end else if (w_drop) begin
          emit     = 1'b1;
          e_status = ST_DROP;
          e_seq    = seq_lo;
          e_trim   = plen_r;
          e_s      = syn_r;
          e_e      = fin_r;
        end else begin
          if (w_ovl) begin
            len_r_next  = len_r - extra;
            trim_r_next = trim_r + extra;
            seq_r_next  = seq_r + {48'd0, extra};
          end
          prev_next = rdata;
          pos_next  = pos_inc;
          if (w_more) begin
            rd_en = 1'b1;
            ra    = pos_inc[IW-1:0];
          end
        end
      end
      // classify, join with a consumed adjacent predecessor, insert at the tail, or start opening a slot
      S_DECIDE: begin
        e_seq  = seq_lo;
        e_cnt  = len_r;
        e_trim = trim_r;
        e_s    = syn_r;
        e_e    = fin_r;
        if (d_empty) begin
          emit     = 1'b1;
          e_status = ST_EMPTY;
        end else if (d_before) begin
          emit     = 1'b1;
          e_status = ST_BEFORE;
        end else if (d_full) begin
          emit     = 1'b1;
          e_status = ST_FULL;
        end else if (d_pred) begin
          wd.st    = syn_r | (prev.st && prev.len == 16'd0);
          we       = 1'b1;
          wa       = pos[IW-1:0] - IW'(1);
          emit     = 1'b1;
          e_status = ST_INSERTED;
          e_s      = wd.st;
        end else if (used > pos) begin
          k_next = used;
          rd_en  = 1'b1;
          ra     = used[IW-1:0] - IW'(1);
        end else begin
          we        = 1'b1;
          wa        = pos[IW-1:0];
          used_next = used + CW'(1);
          emit      = 1'b1;
          e_status  = ST_INSERTED;
        end
      end
      // open a slot, one entry per cycle from the tail
      S_SHIFT_UP: begin
        we = 1'b1;
        wa = k[IW-1:0];
        wd = rdata;
        if (su_more) begin
          k_next = k - CW'(1);
          rd_en  = 1'b1;
          ra     = k[IW-1:0] - IW'(2);
        end
      end
      S_INSERT: begin
        we        = 1'b1;
        wa        = pos[IW-1:0];
        used_next = used + CW'(1);
        emit      = 1'b1;
        e_status  = ST_INSERTED;
        e_seq     = seq_lo;
        e_cnt     = len_r;
        e_trim    = trim_r;
        e_s       = syn_r;
        e_e       = fin_r;
      end
      // front entry is in rdata
      S_CON_RD: begin
        e_seq = rdata.seq[31:0] + {16'd0, rdata.rp};
        e_s   = rdata.st;
        e_e   = rdata.en;
        if (c_read_all) begin
          emit = 1'b1;
          if ({{(32-CW){1'b0}}, used} > 32'(MAX_FUTURE)) begin
            e_status = ST_GAP;
          end
        end else if (c_req0) begin
          emit = 1'b1;
        end else begin
          wd    = rdata;
          wd.rp = rdata.rp + c_chunk;
          we    = 1'b1;
          wa    = '0;
          fr_next  = rdata;
          chk_next = c_chunk;
          if (c_pop_try) begin
            rd_en = 1'b1;
            ra    = IW'(1);
          end else begin
            emit     = 1'b1;
            e_status = ST_DATA;
            e_cnt    = c_chunk;
          end
        end
      end
      S_CON_CHK: begin
        k_next = '0;
        if (!c_match) begin
          emit     = 1'b1;
          e_status = ST_DATA;
          e_seq    = fr.seq[31:0] + {16'd0, fr.rp};
          e_cnt    = chk;
          e_s      = fr.st;
          e_e      = fr.en;
        end
      end
      // pop the front, moving entries down one per cycle
      S_SHIFT_DN: begin
        we = 1'b1;
        wa = k[IW-1:0];
        wd = rdata;
        if (sd_more) begin
          k_next = k + CW'(1);
          rd_en  = 1'b1;
          ra     = k[IW-1:0] + IW'(2);
        end else begin
          used_next = used - CW'(1);
          emit      = 1'b1;
          e_status  = ST_DATA;
          e_seq     = fr.seq[31:0] + {16'd0, fr.rp};
          e_cnt     = chk;
          e_s       = fr.st;
          e_e       = fr.en;
        end
      end
      default: begin
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      ww    <= WRAP_RESET;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      done  <= emit;
      if (cfg_valid && cfg_ready) begin
        ww <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    k      <= k_next;
    seq_r  <= seq_r_next;
    len_r  <= len_r_next;
    plen_r <= plen_r_next;
    trim_r <= trim_r_next;
    req_r  <= req_r_next;
    syn_r  <= syn_r_next;
    fin_r  <= fin_r_next;
    prev   <= prev_next;
    fr     <= fr_next;
    chk    <= chk_next;
    if (emit) begin
      status          <= e_status;
      seq_out         <= e_seq;
      byte_count      <= e_cnt;
      trim_front      <= e_trim;
      start_of_stream <= e_s;
      end_of_stream   <= e_e;
      queue_count     <= 5'(used_next);
    end
  end

  assign busy      = state != S_IDLE;
  assign cfg_ready = 1'b1;

endmodule

// File: test/tb_top.sv
module tb_top;
  import tsra_pkg::*;

  localparam int DEPTH = 16;
  localparam int FUTURE_LIMIT = 15;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_REQUESTS = 1200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        operation = OP_STORE;
  logic [31:0] seq_number = '0;
  logic [15:0] payload_len = '0;
  logic        syn_flag = 1'b0;
  logic        fin_or_rst = 1'b0;
  logic [15:0] request_len = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        done;
  logic [3:0]  status;
  logic [31:0] seq_out;
  logic [15:0] byte_count;
  logic [15:0] trim_front;
  logic        start_of_stream;
  logic        end_of_stream;
  logic [4:0]  queue_count;

  typedef struct packed {
    logic [3:0]  st;
    logic [31:0] seq;
    logic [15:0] cnt;
    logic [15:0] trim;
    logic        sos;
    logic        eos;
    logic [4:0]  qc;
  } seg_result_t;

  // one row of the directed table; check_known selects the typed-in result
  typedef struct packed {
    logic        op;
    logic [31:0] seq;
    logic [15:0] plen;
    logic        syn;
    logic        fin;
    logic [15:0] req;
    logic        check_known;
    seg_result_t known;
  } seg_row_t;

  tcp_segment_reassembly_table_top i_dut (.*);

  always #5 clk = ~clk;

  // shadow copy of the descriptor table
  entry_t      tbl [DEPTH];
  int unsigned tbl_used;
  logic [31:0] shadow_window;

  seg_result_t pending_results[$];
  int          error_count = 0;
  int unsigned cycle_count = 0;
  logic        idle_ok = 1'b1;

  function automatic seg_result_t make_result(logic [3:0] st, logic [63:0] seq,
      logic [63:0] cnt, logic [63:0] trim, logic sos, logic eos);
    seg_result_t r;
    r.st = st; r.seq = seq[31:0]; r.cnt = cnt[15:0]; r.trim = trim[15:0];
    r.sos = sos; r.eos = eos; r.qc = tbl_used[4:0];
    return r;
  endfunction

  function automatic void drop_entry(int unsigned p);
    for (int unsigned k = p; k + 1 < tbl_used; k++) tbl[k] = tbl[k+1];
    tbl_used--;
  endfunction

  // store: extend sequence, walk, trim/merge/drop, insert
  function automatic seg_result_t predict_store(logic [31:0] sn, logic [15:0] pl,
      logic syn, logic fin);
    logic [63:0] seq, len, plen, trim, ww, msb, dseq, dlen, diff, extra, fs;
    int unsigned pos;
    logic sflag;
    seq = {32'd0, sn + {31'd0, syn}};
    len = {48'd0, pl};
    plen = len;
    trim = 0;
    ww = {32'd0, shadow_window};
    pos = 0;
    sflag = syn;
    if (tbl_used > 0) begin
      fs = {32'd0, tbl[0].seq[31:0]};
      msb = {32'd0, tbl[0].seq[63:32]};
      if (seq > 64'hFFFF_FFFF - ww && fs < ww) msb = msb - 1;
      else if (fs > 64'hFFFF_FFFF - ww && seq < ww) msb = msb + 1;
      seq = seq | (msb << 32);
    end
    while (pos < tbl_used) begin
      dseq = tbl[pos].seq;
      dlen = {48'd0, tbl[pos].len};
      if (seq == dseq) begin
        if (len > dlen) tbl[pos].len = len[15:0];
        return make_result(ST_MERGED, dseq, tbl[pos].len, trim, tbl[pos].st,
                           tbl[pos].en);
      end else if (seq < dseq) begin
        diff = dseq - seq;
        if (len > diff) len = diff;
        break;
      end else begin
        diff = seq - dseq;
        if (dlen > diff) begin
          extra = dlen - diff;
          if (len <= extra) return make_result(ST_DROP, seq, 0, plen, syn, fin);
          len -= extra;
          trim += extra;
          seq += extra;
        end
      end
      pos++;
    end
    if (len == 0 && !syn && !fin) return make_result(ST_EMPTY, seq, len, trim, syn, fin);
    if (tbl_used > 0 && pos == 0) return make_result(ST_BEFORE, seq, len, trim, syn, fin);
    if (tbl_used >= DEPTH) return make_result(ST_FULL, seq, len, trim, syn, fin);
    for (int unsigned k = tbl_used; k > pos; k--) tbl[k] = tbl[k-1];
    tbl[pos].seq = seq; tbl[pos].len = len[15:0]; tbl[pos].rp = '0;
    tbl[pos].st = syn; tbl[pos].en = fin;
    tbl_used++;
    // a fully read, adjacent predecessor is dropped; its start flag carries over only when it is empty
    if (pos > 0) begin
      if (tbl[pos-1].rp >= tbl[pos-1].len &&
          tbl[pos-1].seq + {48'd0, tbl[pos-1].len} == seq) begin
        if (tbl[pos-1].st && tbl[pos-1].len == 0) tbl[pos].st = 1'b1;
        sflag = tbl[pos].st;
        drop_entry(pos - 1);
      end
    end
    return make_result(ST_INSERTED, seq, len, trim, sflag, fin);
  endfunction

  // consume: hand out a chunk of the front entry
  function automatic seg_result_t predict_consume(logic [15:0] req);
    logic [63:0] fseq, rp, len, chunk;
    entry_t f;
    if (tbl_used == 0) return make_result(ST_NONE, 0, 0, 0, 0, 0);
    f = tbl[0];
    fseq = f.seq; rp = {48'd0, f.rp}; len = {48'd0, f.len};
    if (rp >= len)
      return make_result(tbl_used > FUTURE_LIMIT ? ST_GAP : ST_NONE, fseq + rp, 0, 0,
                         f.st, f.en);
    if (req == 0) return make_result(ST_NONE, fseq + rp, 0, 0, f.st, f.en);
    chunk = len - rp;
    if ({48'd0, req} < chunk) chunk = {48'd0, req};
    tbl[0].rp = rp[15:0] + chunk[15:0];
    if (!f.en && rp + chunk >= len && tbl_used >= 2 && tbl[1].seq == fseq + len)
      drop_entry(0);
    return make_result(ST_DATA, fseq + rp, chunk, 0, f.st, f.en);
  endfunction

  // result checker
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, status);
        error_count++;
      end else begin
        seg_result_t e;
        seg_result_t a;
        e = pending_results[0];
        pending_results.delete(0);
        a = '{status, seq_out, byte_count, trim_front, start_of_stream,
              end_of_stream, queue_count};
        if (a !== e) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, a);
          error_count++;
        end
      end
    end
  end

  // timeout watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // issue one request and wait for acceptance; start stays high until the
  // next request or idle cycle takes it over
  task automatic send_request(logic op, logic [31:0] sn, logic [15:0] pl, logic syn,
      logic fin, logic [15:0] req, logic chk, seg_result_t known);
    seg_result_t e;
    while (idle_ok && $urandom_range(99) < 30) begin
      start <= 1'b0;
      @(posedge clk);
    end
    operation <= op; seq_number <= sn; payload_len <= pl;
    syn_flag <= syn; fin_or_rst <= fin; request_len <= req;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    e = (op == OP_STORE) ? predict_store(sn, pl, syn, fin) : predict_consume(req);
    if (chk && known !== e) begin
      $display("%0t: table row mismatch expected %p predicted %p", $time, known, e);
      error_count++;
    end
    pending_results.push_back(e);
  endtask

  task automatic write_window(logic [31:0] value);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1; cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_window = value;
  endtask

  function automatic logic [31:0] near_seq(logic [31:0] base);
    case ($urandom_range(9))
      0: return $urandom;
      1: return base - $urandom_range(2000);
      default: return base + $urandom_range(3000);
    endcase
  endfunction

  seg_row_t rows [$];

  initial begin
    logic [31:0] base;
    int unsigned phase;
    for (int k = 0; k < DEPTH; k++) tbl[k] = '0;
    tbl_used = 0;
    shadow_window = WRAP_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    rows.push_back('{OP_CONSUME, 0, 0, 0, 0, 16'd10, 1, '{ST_NONE, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{OP_STORE, 32'hFFFF_FFFF, 0, 0, 0, 0, 1,
                     '{ST_EMPTY, 32'hFFFF_FFFF, 0, 0, 0, 0, 0}});
    rows.push_back('{OP_STORE, 32'hFFFF_FFFF, 16'd100, 1, 0, 0, 1,
                     '{ST_INSERTED, 0, 16'd100, 0, 1, 0, 1}});
    rows.push_back('{OP_STORE, 32'd0, 16'd200, 0, 0, 0, 1,
                     '{ST_MERGED, 0, 16'd200, 0, 1, 0, 1}});
    rows.push_back('{OP_STORE, 32'd50, 16'd20, 0, 0, 0, 1,
                     '{ST_DROP, 32'd50, 0, 16'd20, 0, 0, 1}});
    rows.push_back('{OP_STORE, 32'd150, 16'd100, 0, 1, 0, 0, '0});
    rows.push_back('{OP_STORE, 32'hFFFF_FF00, 16'd10, 0, 0, 0, 0, '0});
    rows.push_back('{OP_STORE, 32'd500, 16'hFFFF, 0, 0, 0, 0, '0});
    rows.push_back('{OP_STORE, 32'd400, 16'd100, 0, 0, 0, 0, '0});
    rows.push_back('{OP_CONSUME, 0, 0, 0, 0, 16'd0, 0, '0});
    rows.push_back('{OP_CONSUME, 0, 0, 0, 0, 16'd50, 0, '0});
    rows.push_back('{OP_CONSUME, 0, 0, 0, 0, 16'hFFFF, 0, '0});
    rows.push_back('{OP_CONSUME, 0, 0, 0, 0, 16'hFFFF, 0, '0});
    rows.push_back('{OP_CONSUME, 0, 0, 0, 0, 16'hFFFF, 0, '0});
    rows.push_back('{OP_STORE, 32'd300, 16'd0, 0, 1, 0, 0, '0});
    rows.push_back('{OP_CONSUME, 0, 0, 0, 0, 16'hFFFF, 0, '0});
    rows.push_back('{OP_CONSUME, 0, 0, 0, 0, 16'h1, 0, '0});
    for (int r = 0; r < 18; r++)
      rows.push_back('{OP_STORE, 32'd70000 + 32'(r) * 32'd10, 16'd5, 0, 0, 0, 0, '0});
    foreach (rows[i])
      send_request(rows[i].op, rows[i].seq, rows[i].plen, rows[i].syn, rows[i].fin,
                   rows[i].req, rows[i].check_known, rows[i].known);

    // random phases across window settings, with a stretch of no idling
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_window(32'd0);
        1: write_window(32'hFFFF_FFFF);
        2: write_window(32'd14600);
        3: write_window($urandom);
        4: write_window(32'h8000_0000);
        default: write_window(32'd4000);
      endcase
      idle_ok = (phase != 2);
      // pick a base sequence for the phase, near the wrap point in odd phases
      base = (phase % 2) ? 32'hFFFF_F000 + $urandom_range(4000) : $urandom;
      for (int n = 0; n < RANDOM_REQUESTS / 6; n++) begin
        logic [15:0] pl;
        logic [15:0] rq;
        pl = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(600));
        rq = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(700));
        if ($urandom_range(99) < 40)
          send_request(OP_CONSUME, $urandom, 16'($urandom), 1'($urandom), 1'($urandom),
                       rq, 1'b0, '0);
        else begin
          logic [31:0] s;
          s = near_seq(base);
          send_request(OP_STORE, s, pl, $urandom_range(15) == 0,
                       $urandom_range(9) == 0, 16'($urandom), 1'b0, '0);
          if ($urandom_range(7) == 0) base = base + $urandom_range(1500);
        end
      end
      // consume before the next phase until the table is empty or its front entry is fully read
      while (tbl_used > 0 && cycle_count < CYCLE_LIMIT / 2) begin
        if (tbl[0].rp >= tbl[0].len) begin
          base = $urandom;
          write_window(shadow_window);
          break;
        end
        send_request(OP_CONSUME, 0, 0, 0, 0, 16'hFFFF, 0, '0);
      end
    end
    idle_ok = 1'b1;
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
